// ===== rtl/npid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npid_pkg
// Shared types, constants and datapath operation codes of the PID regulator.
// ----------------------------------------------------------------------------
package npid_pkg;

  localparam int DIV_W  = 48;   // dividend and quotient width of the serial divider
  localparam int DEN_W  = 9;    // divisor width (up to 256)
  localparam int CNT_W  = 6;    // divider step counter, holds DIV_W
  localparam int TOT_W  = 48;   // running total width

  localparam int DRIVE_LIMIT = 50;
  localparam int P_DIVISOR   = 100;
  localparam int WORD_MAX    = 32767;

  localparam logic [2:0] REG_P_GAIN = 3'd0;
  localparam logic [2:0] REG_I_GAIN = 3'd1;
  localparam logic [2:0] REG_D_GAIN = 3'd2;
  localparam logic [2:0] REG_SCALE  = 3'd3;
  localparam logic [2:0] REG_HYST   = 3'd4;
  localparam logic [2:0] REG_D_EN   = 3'd5;

  typedef struct packed {
    logic [7:0]  p_gain;
    logic [7:0]  i_gain;
    logic [7:0]  d_gain;
    logic [7:0]  scale;
    logic [15:0] hysteresis;
    logic        derivative_enable;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT_PDIV,
    OP_INIT_PSET,
    OP_INIT_IDIV,
    OP_INIT_ISET,
    OP_THR_DIV,
    OP_SUM,
    OP_E2_DIV,
    OP_PMUL,
    OP_PADD,
    OP_DSQ,
    OP_D_DIV,
    OP_DMUL,
    OP_DADD,
    OP_OMUL,
    OP_HYST,
    OP_R_DIV,
    OP_RES
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic i_zero;
    logic d_en;
    logic hold;
    logic div_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/npid_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npid_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module npid_div (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire [npid_pkg::DIV_W-1:0] num,
  input  wire [npid_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [npid_pkg::DIV_W-1:0] quo
);
  import npid_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic             take;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], take};
      rem <= take ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/npid_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npid_dp
// Regulator datapath: error, clamped sum, P/D terms, hold band, output clamp.
// ----------------------------------------------------------------------------
module npid_dp (
  input  wire                clk,
  input  wire                rst,
  input  npid_pkg::cfg_t     cfg,
  input  npid_pkg::cmd_t     cmd,
  output npid_pkg::stat_t    stat,
  input  wire                kind,
  input  wire signed [14:0]  set_point,
  input  wire signed [14:0]  process_value,
  input  wire signed [6:0]   previous_drive,
  output logic signed [6:0]  drive
);
  import npid_pkg::*;

  // ceil(2^33 / 25): (sq >> 2) * E2_RECIP >> 33 is sq / 100 for sq < 2^30
  localparam logic [28:0] E2_RECIP = 29'd343597384;

  logic                     kind_r;
  logic signed [14:0]       sp_r, pv_r;
  logic signed [6:0]        old_r;
  logic signed [16:0]       err_r, dd_r;
  logic [31:0]              sq;
  logic signed [TOT_W-1:0]  prod, total;
  logic signed [15:0]       error_sum, last_process;
  logic [15:0]              p_lim, sum_lim;

  logic                     div_start, div_busy;
  logic [DIV_W-1:0]         div_num, div_q;
  logic [DEN_W-1:0]         div_den, scale_nz;

  logic [15:0]              err_mag, dd_mag;
  logic signed [17:0]       sum_raw, sum_lim_s;
  logic signed [TOT_W-1:0]  diff;
  logic [TOT_W-1:0]         diff_mag, total_mag;
  logic                     hold_c;
  logic [5:0]               res_mag;

  logic [56:0]              e2_prod;
  logic [23:0]              e2_q;
  logic signed [24:0]       isum_prod;
  logic [31:0]              pterm;
  logic [39:0]              dterm;
  logic signed [15:0]       oterm;

  npid_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  assign scale_nz  = (cfg.scale == 8'd0) ? DEN_W'(1) : {1'b0, cfg.scale};
  assign err_mag   = err_r[16] ? 16'(-err_r) : 16'(err_r);
  assign dd_mag    = dd_r[16] ? 16'(-dd_r) : 16'(dd_r);
  assign sum_raw   = 18'(error_sum) + (({32'd0, err_mag} < div_q) ? 18'(err_r) : 18'sd0);
  assign sum_lim_s = $signed({2'b00, sum_lim});
  assign diff      = total - prod;
  assign diff_mag  = diff[TOT_W-1] ? TOT_W'(-diff) : TOT_W'(diff);
  assign total_mag = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
  assign hold_c    = diff_mag < {32'd0, cfg.hysteresis};
  assign res_mag   = (div_q > DIV_W'(DRIVE_LIMIT)) ? 6'(DRIVE_LIMIT) : div_q[5:0];

  assign e2_prod   = sq[29:2] * E2_RECIP;
  assign isum_prod = $signed({1'b0, cfg.i_gain}) * error_sum;
  assign pterm     = cfg.p_gain * e2_q;
  assign dterm     = cfg.d_gain * div_q[31:0];
  assign oterm     = old_r * $signed({1'b0, cfg.scale});

  assign stat.kind     = kind_r;
  assign stat.i_zero   = (cfg.i_gain == 8'd0);
  assign stat.d_en     = cfg.derivative_enable;
  assign stat.hold     = hold_c;
  assign stat.div_busy = div_busy;

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_W'(1);
    case (cmd.op)
      OP_INIT_PDIV: begin
        div_start = 1'b1;
        div_num   = DIV_W'(WORD_MAX);
        div_den   = {1'b0, cfg.p_gain} + DEN_W'(1);
      end
      OP_INIT_IDIV: begin
        div_start = 1'b1;
        div_num   = DIV_W'({6'd0, cfg.scale} * 14'd50);
        div_den   = {1'b0, cfg.i_gain};
      end
      OP_THR_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_W'({6'd0, cfg.scale} * 14'd50);
        div_den   = (cfg.p_gain == 8'd0) ? DEN_W'(1) : {1'b0, cfg.p_gain};
      end
      OP_D_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_W'(sq);
        div_den   = scale_nz;
      end
      OP_R_DIV: begin
        div_start = 1'b1;
        div_num   = total_mag;
        div_den   = scale_nz;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // persistent regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum    <= '0;
      last_process <= '0;
      p_lim        <= '0;
      sum_lim      <= '0;
    end else begin
      case (cmd.op)
        OP_INIT_PSET: begin
          p_lim        <= div_q[15:0];
          last_process <= 16'(pv_r);
        end
        OP_INIT_ISET: begin
          sum_lim <= stat.i_zero ? 16'(WORD_MAX) : div_q[15:0];
        end
        OP_SUM: begin
          if (sum_raw > sum_lim_s) begin
            error_sum <= 16'(sum_lim_s);
          end else if (sum_raw < -sum_lim_s) begin
            error_sum <= 16'(-sum_lim_s);
          end else begin
            error_sum <= 16'(sum_raw);
          end
        end
        OP_DADD: begin
          last_process <= 16'(pv_r);
        end
        default: begin
        end
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= kind;
        sp_r   <= set_point;
        pv_r   <= process_value;
        old_r  <= previous_drive;
      end
      OP_THR_DIV: begin
        err_r <= 17'(sp_r) - 17'(pv_r);
        dd_r  <= 17'(last_process) - 17'(pv_r);
      end
      OP_SUM: begin
        sq <= err_mag * err_mag;
      end
      OP_E2_DIV: begin
        e2_q  <= e2_prod[56:33];
        total <= TOT_W'(isum_prod);
      end
      OP_PMUL: begin
        prod <= TOT_W'(pterm);
      end
      OP_PADD: begin
        if (e2_q > {8'd0, p_lim}) begin
          total <= err_r[16] ? total - TOT_W'(WORD_MAX) : total + TOT_W'(WORD_MAX);
        end else begin
          total <= err_r[16] ? total - prod : total + prod;
        end
      end
      OP_DSQ: begin
        sq <= dd_mag * dd_mag;
      end
      OP_DMUL: begin
        prod <= TOT_W'(dterm);
      end
      OP_DADD: begin
        total <= dd_r[16] ? total - prod : total + prod;
      end
      OP_OMUL: begin
        prod <= TOT_W'(oterm);
      end
      OP_RES: begin
        if (hold_c) begin
          drive <= old_r;
        end else begin
          drive <= total[TOT_W-1] ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/npid_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npid_ctrl
// Sequencer: steps the datapath through init or control, owns the handshakes.
// ----------------------------------------------------------------------------
module npid_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  npid_pkg::stat_t  stat,
  output npid_pkg::cmd_t   cmd
);
  import npid_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE   = 25'd1 << 0,
    S_DISP   = 25'd1 << 1,
    S_IPDIV  = 25'd1 << 2,
    S_IPWAIT = 25'd1 << 3,
    S_IPSET  = 25'd1 << 4,
    S_IIDIV  = 25'd1 << 5,
    S_IIWAIT = 25'd1 << 6,
    S_IISET  = 25'd1 << 7,
    S_THR    = 25'd1 << 8,
    S_THRW   = 25'd1 << 9,
    S_SUM    = 25'd1 << 10,
    S_E2     = 25'd1 << 11,
    S_E2W    = 25'd1 << 12,
    S_PMUL   = 25'd1 << 13,
    S_PADD   = 25'd1 << 14,
    S_DSQ    = 25'd1 << 15,
    S_DDIV   = 25'd1 << 16,
    S_DDIVW  = 25'd1 << 17,
    S_DMUL   = 25'd1 << 18,
    S_DADD   = 25'd1 << 19,
    S_OMUL   = 25'd1 << 20,
    S_HYST   = 25'd1 << 21,
    S_RDIV   = 25'd1 << 22,
    S_RDIVW  = 25'd1 << 23,
    S_RES    = 25'd1 << 24
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP:   state_next = stat.kind ? S_IPDIV : S_THR;
      S_IPDIV: begin
        cmd.op     = OP_INIT_PDIV;
        state_next = S_IPWAIT;
      end
      S_IPWAIT: if (!stat.div_busy) state_next = S_IPSET;
      S_IPSET: begin
        cmd.op     = OP_INIT_PSET;
        state_next = stat.i_zero ? S_IISET : S_IIDIV;
      end
      S_IIDIV: begin
        cmd.op     = OP_INIT_IDIV;
        state_next = S_IIWAIT;
      end
      S_IIWAIT: if (!stat.div_busy) state_next = S_IISET;
      S_IISET: begin
        cmd.op     = OP_INIT_ISET;
        state_next = S_IDLE;
      end
      S_THR: begin
        cmd.op     = OP_THR_DIV;
        state_next = S_THRW;
      end
      S_THRW:   if (!stat.div_busy) state_next = S_SUM;
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_E2;
      end
      S_E2: begin
        cmd.op     = OP_E2_DIV;
        state_next = S_E2W;
      end
      S_E2W:    if (!stat.div_busy) state_next = S_PMUL;
      S_PMUL: begin
        cmd.op     = OP_PMUL;
        state_next = S_PADD;
      end
      S_PADD: begin
        cmd.op     = OP_PADD;
        state_next = stat.d_en ? S_DSQ : S_OMUL;
      end
      S_DSQ: begin
        cmd.op     = OP_DSQ;
        state_next = S_DDIV;
      end
      S_DDIV: begin
        cmd.op     = OP_D_DIV;
        state_next = S_DDIVW;
      end
      S_DDIVW:  if (!stat.div_busy) state_next = S_DMUL;
      S_DMUL: begin
        cmd.op     = OP_DMUL;
        state_next = S_DADD;
      end
      S_DADD: begin
        cmd.op     = OP_DADD;
        state_next = S_OMUL;
      end
      S_OMUL: begin
        cmd.op     = OP_OMUL;
        state_next = S_HYST;
      end
      S_HYST: begin
        cmd.op     = OP_HYST;
        state_next = stat.hold ? S_RES : S_RDIV;
      end
      S_RDIV: begin
        cmd.op     = OP_R_DIV;
        state_next = S_RDIVW;
      end
      S_RDIVW:  if (!stat.div_busy) state_next = S_RES;
      S_RES: begin
        if (slot_free) begin
          cmd.op     = OP_RES;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RES && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nonlinear_pid_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonlinear_pid_controller
// Non-linear PID regulator with integral anti-windup for a valve drive.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, kind, set_point,       | sink
//          | process_value, previous_drive             |
//  out     | out_valid/out_ready, drive                | source
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | APB slave
//          | prdata, pready                            |
//
// One item at a time. An init beat runs two divisions, one when i_gain is
// zero. A control beat runs more divisions with the D term on and one fewer
// when the hold band applies; all of them share the serial divider. rst is
// synchronous: it restores register defaults and clears the sequencer,
// out_valid and the regulator state, but not the working registers. A
// finished result waits in the drive register; the next input beat is
// accepted meanwhile, and only the final step stalls until the slot frees.
// ----------------------------------------------------------------------------
module nonlinear_pid_controller (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               kind,
  input  wire signed [14:0] set_point,
  input  wire signed [14:0] process_value,
  input  wire signed [6:0]  previous_drive,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [6:0] drive,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [4:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import npid_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register file: write at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain            <= 8'd1;
      cfg.i_gain            <= 8'd0;
      cfg.d_gain            <= 8'd0;
      cfg.scale             <= 8'd100;
      cfg.hysteresis        <= 16'd0;
      cfg.derivative_enable <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_P_GAIN: cfg.p_gain            <= pwdata[7:0];
        REG_I_GAIN: cfg.i_gain            <= pwdata[7:0];
        REG_D_GAIN: cfg.d_gain            <= pwdata[7:0];
        REG_SCALE:  cfg.scale             <= pwdata[7:0];
        REG_HYST:   cfg.hysteresis        <= pwdata[15:0];
        REG_D_EN:   cfg.derivative_enable <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      REG_P_GAIN: prdata = {24'd0, cfg.p_gain};
      REG_I_GAIN: prdata = {24'd0, cfg.i_gain};
      REG_D_GAIN: prdata = {24'd0, cfg.d_gain};
      REG_SCALE:  prdata = {24'd0, cfg.scale};
      REG_HYST:   prdata = {16'd0, cfg.hysteresis};
      REG_D_EN:   prdata = {31'd0, cfg.derivative_enable};
      default:    prdata = 32'd0;
    endcase
  end

  // sequencer: owns both handshakes, one datapath op per cycle unless waiting
  npid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: holds regulator state, the shared divider and the drive register
  npid_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .set_point      (set_point),
    .process_value  (process_value),
    .previous_drive (previous_drive),
    .drive          (drive)
  );

`ifndef ASSERT_OFF
  // never restart the divider while it is still working
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INIT_PDIV || cmd.op == OP_INIT_IDIV || cmd.op == OP_THR_DIV ||
     cmd.op == OP_D_DIV || cmd.op == OP_R_DIV)
    |-> !stat.div_busy)
    else $error("divider started while busy");

  // a threshold or result division must be running on the next cycle
  a_div_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_THR_DIV || cmd.op == OP_R_DIV) |=> stat.div_busy)
    else $error("divider did not start");

  // one item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open while an item is in work");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the non-linear PID regulator: an in-bench predictor
// tracks limits, integral sum and last process value, and every drive beat is
// compared in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb;
  import npid_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic signed [14:0] set_point = '0;
  logic signed [14:0] process_value = '0;
  logic signed [6:0] previous_drive = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [6:0] drive;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nonlinear_pid_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .set_point(set_point), .process_value(process_value),
    .previous_drive(previous_drive),
    .out_valid(out_valid), .out_ready(out_ready), .drive(drive),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor copy of the registers and the regulator state.
  cfg_t model_cfg;
  longint last_pv, err_sum, err_limit, sum_lim;

  logic signed [6:0] drive_q[$];
  int mismatches = 0;
  int drive_beats = 0;
  int step_beats = 0;
  int init_beats = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit out_stalls = 1'b0;
  bit in_gaps = 1'b0;
  int hold_off = 0;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint nonzero(longint v);
    return v == 0 ? 1 : v;
  endfunction

  // Advance the predictor by one beat; push a drive value for control steps.
  function automatic void predict_drive(logic k, logic signed [14:0] sp,
                                        logic signed [14:0] pv,
                                        logic signed [6:0] old);
    longint err, sum, total, e2, d, res, spl, pvl, oldl, sc;
    spl = sp; pvl = pv; oldl = old; sc = model_cfg.scale;
    if (k) begin
      last_pv = pvl;
      err_limit = WORD_MAX / (longint'(model_cfg.p_gain) + 1);
      if (model_cfg.i_gain == 0) sum_lim = WORD_MAX;
      else sum_lim = (sc * 50) / longint'(model_cfg.i_gain);
      return;
    end
    err = spl - pvl;
    sum = err_sum;
    if (abs64(err) < (sc * 50) / nonzero(model_cfg.p_gain)) sum += err;
    if (sum > sum_lim) sum = sum_lim;
    else if (sum < -sum_lim) sum = -sum_lim;
    err_sum = sum;
    total = longint'(model_cfg.i_gain) * sum;
    e2 = (err * abs64(err)) / P_DIVISOR;
    if (e2 > err_limit) total += WORD_MAX;
    else if (e2 < -err_limit) total -= WORD_MAX;
    else total += longint'(model_cfg.p_gain) * e2;
    if (model_cfg.derivative_enable) begin
      d = last_pv - pvl;
      d = (d * abs64(d)) / nonzero(sc);
      total += d * longint'(model_cfg.d_gain);
      last_pv = pvl;
    end
    if (abs64(total - oldl * sc) < longint'(model_cfg.hysteresis)) begin
      res = oldl;
    end else begin
      res = total / nonzero(sc);
      if (res > DRIVE_LIMIT) res = DRIVE_LIMIT;
      else if (res < -DRIVE_LIMIT) res = -DRIVE_LIMIT;
    end
    drive_q.push_back(res[6:0]);
  endfunction

  // Random idle bursts; none during the final phase.
  bit quiet_tail = 1'b0;

  function automatic int idle_burst();
    if (quiet_tail || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  // Send one input beat and update the predictor when it is accepted.
  // Valid stays up between back-to-back beats; drop it only for a gap.
  task automatic send_beat(logic k, logic signed [14:0] sp, logic signed [14:0] pv,
                           logic signed [6:0] old);
    int gap;
    gap = idle_burst();
    if (gap > 0) begin
      in_gaps = 1'b1;
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    set_point <= sp;
    process_value <= pv;
    previous_drive <= old;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_drive(k, sp, pv, old);
    if (k) init_beats++;
    else step_beats++;
  endtask

  // Wait until every predicted drive has come back, then let the block settle
  // so an init still in flight finishes before registers change.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; the bus is left selected for a following write.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_P_GAIN: model_cfg.p_gain = value[7:0];
      REG_I_GAIN: model_cfg.i_gain = value[7:0];
      REG_D_GAIN: model_cfg.d_gain = value[7:0];
      REG_SCALE:  model_cfg.scale = value[7:0];
      REG_HYST:   model_cfg.hysteresis = value[15:0];
      REG_D_EN:   model_cfg.derivative_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic set_all(int pg, int ig, int dg, int sc, int hy, int de);
    write_reg(REG_P_GAIN, pg);
    write_reg(REG_I_GAIN, ig);
    write_reg(REG_D_GAIN, dg);
    write_reg(REG_SCALE, sc);
    write_reg(REG_HYST, hy);
    write_reg(REG_D_EN, de);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [14:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 15'($urandom_range(0, 32767));
      1: return $signed(15'($urandom_range(0, 400))) - 15'sd200;
      2: return $signed(15'($urandom_range(0, 4000))) - 15'sd2000;
      default: return $urandom_range(0, 1) ? 15'sh3FFF : 15'sh4000;
    endcase
  endfunction

  function automatic logic signed [6:0] rand_old();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return $signed(7'($urandom_range(0, 100))) - 7'sd50;
  endfunction

  // Check each drive beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      drive_beats++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected drive %0d", drive);
      end else begin
        if (drive !== drive_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: drive mismatch exp %0d got %0d", drive_q[0], drive);
        end
        void'(drive_q.pop_front());
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when requested.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      int g;
      g = idle_burst();
      if (g > 0) out_stalls = 1'b1;
      stall_left <= g;
      out_ready <= (g == 0);
    end
  end

  // Watchdog: count cycles with no beat on either channel and no hold-off.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic test_directed_limits();
    // Control before any init: zero limits saturate P, sum stays zero.
    send_beat(1'b0, 15'sd100, 15'sd0, 7'sd0);
    send_beat(1'b0, 15'sd0, 15'sd0, 7'sd0);
    send_beat(1'b1, 15'sd0, 15'sd0, 7'sd0);
    send_beat(1'b0, 15'sh3FFF, 15'sh4000, 7'sd50);
    send_beat(1'b0, 15'sh4000, 15'sh3FFF, -7'sd50);
    send_beat(1'b0, 15'sd5, 15'sd3, 7'sd0);
    send_beat(1'b0, 15'sd5, 15'sd3, 7'sh3F);
    send_beat(1'b0, 15'sd5, 15'sd3, 7'sh40);
    drain_outputs();
  endtask

  task automatic test_directed_gains();
    set_all(255, 255, 255, 255, 65535, 1);
    send_beat(1'b1, 15'sd7, 15'sh3FFF, 7'sd3);
    send_beat(1'b0, 15'sd0, 15'sh4000, 7'sh3F);
    send_beat(1'b0, 15'sd20, 15'sd10, 7'sh40);
    drain_outputs();
    set_all(0, 0, 255, 0, 0, 1);
    send_beat(1'b1, 15'sd0, 15'sd0, 7'sd0);
    send_beat(1'b0, 15'sd1, 15'sh3FFF, 7'sd0);
    send_beat(1'b0, -15'sd1, 15'sh4000, 7'sd0);
    send_beat(1'b0, 15'sd3, 15'sd2, 7'sd9);
    drain_outputs();
    set_all(3, 7, 2, 1, 10, 0);
    send_beat(1'b1, 15'sd0, 15'sd50, 7'sd0);
    send_beat(1'b0, 15'sd60, 15'sd0, 7'sd1);
    send_beat(1'b0, -15'sd60, 15'sd2000, 7'sd1);
    send_beat(1'b0, 15'sd4, 15'sd4, 7'sd0);
    drain_outputs();
  endtask

  task automatic run_random(int beats);
    repeat (beats) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(1'b1, rand_value(), rand_value(), rand_old());
      else
        send_beat(1'b0, rand_value(), rand_value(), rand_old());
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      set_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 300),
              $urandom_range(0, 1));
      send_beat(1'b1, rand_value(), rand_value(), rand_old());
      run_random(70);
      drain_outputs();
    end
  endtask

  // Hold the receiver off while the sender keeps offering beats.
  task automatic test_backpressure();
    hold_off = 1500;
    run_random(12);
    drain_outputs();
  endtask

  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    set_all(1, 0, 0, 100, 0, 1);
    send_beat(1'b1, 15'sd0, 15'sd0, 7'sd0);
    run_random(40);
  endtask

  initial begin
    model_cfg = '{p_gain: 8'd1, i_gain: 8'd0, d_gain: 8'd0, scale: 8'd100,
                  hysteresis: 16'd0, derivative_enable: 1'b1};
    last_pv = 0; err_sum = 0; err_limit = 0; sum_lim = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_limits();
    test_directed_gains();
    test_random_settings();
    test_backpressure();
    test_quiet_tail();
    drain_outputs();
    $display("tb: %0d control and %0d init beats sent, %0d drive beats checked",
             step_beats, init_beats, drive_beats);
    $display("tb: input gaps %0d, output stalls %0d, mismatches %0d",
             in_gaps, out_stalls, mismatches);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/npid_pkg.sv
rtl/npid_div.sv
rtl/npid_dp.sv
rtl/npid_ctrl.sv
rtl/nonlinear_pid_controller.sv
test/tb.sv
